// File: hw/rtl/class_data_uleb128_stream_decoder_assert.svh
// Assertion macros shared by the decoder checker
`ifndef CLASS_DATA_ULEB128_STREAM_DECODER_ASSERT_SVH
`define CLASS_DATA_ULEB128_STREAM_DECODER_ASSERT_SVH
// Assert an implication on every clock edge outside reset
`define CDU_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Assert an implication that must hold in the next cycle, outside reset
`define CDU_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/cdu_pkg.sv
// Shared types and constants for the class-data decoder
package cdu_pkg;
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_STATIC  = 3'd1;
   localparam logic [2:0] KIND_DIRECT  = 3'd3;
   localparam logic [2:0] KIND_VIRTUAL = 3'd4;
   localparam logic [2:0] PHASE_DONE   = 3'd5;
   localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       record_start;
   } req_type;

   typedef struct packed {
      logic [2:0]  entry_kind;
      logic [31:0] entry_index;
      logic [31:0] entry_flags;
      logic [31:0] entry_code_offset;
      logic [31:0] static_count;
      logic [31:0] instance_count;
      logic [31:0] direct_count;
      logic [31:0] virtual_count;
      logic        last_of_record;
   } rsp_type;

   // Completed LEB128 value passed from front to back
   typedef struct packed {
      logic [31:0] value;
      logic        record_start;
   } word_type;
endpackage

// File: hw/rtl/cdu_front.sv
// Front end: assembles LEB128 values from bytes
module cdu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdu_pkg::req_type req_data,
   output logic             word_valid,
   input  logic             word_ready,
   output cdu_pkg::word_type word_data
);
   import cdu_pkg::*;

   logic [31:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        start_ff, start_in;
   logic [31:0] merged;
   logic [31:0] base;
   logic [2:0]  cnt_eff;
   logic        ends;
   logic        take;

   assign req_ready = word_ready;
   assign take = req_valid && req_ready;

   // Restart the value on record start
   assign base    = req_data.record_start ? 32'd0 : acc_ff;
   assign cnt_eff = req_data.record_start ? 3'd0 : cnt_ff;

   always_comb begin
      case (cnt_eff)
         3'd0: merged = base | {25'd0, req_data.data_byte[6:0]};
         3'd1: merged = base | {18'd0, req_data.data_byte[6:0], 7'd0};
         3'd2: merged = base | {11'd0, req_data.data_byte[6:0], 14'd0};
         3'd3: merged = base | {4'd0, req_data.data_byte[6:0], 21'd0};
         default: merged = base | {req_data.data_byte[3:0], 28'd0};
      endcase
   end

   assign ends = (cnt_eff == 3'd4) || !req_data.data_byte[7];
   assign word_valid = take && ends;
   assign word_data.value = merged;
   assign word_data.record_start = req_data.record_start | start_ff;

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      start_in = start_ff;
      if (take) begin
         if (ends) begin
            acc_in   = 32'd0;
            cnt_in   = 3'd0;
            start_in = 1'b0;
         end else begin
            acc_in   = merged;
            cnt_in   = cnt_eff + 3'd1;
            start_in = start_ff | req_data.record_start;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= 32'd0;
         cnt_ff   <= 3'd0;
         start_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         start_ff <= start_in;
      end
   end
endmodule

// File: hw/rtl/cdu_queue.sv
// Short word queue between front and back
module cdu_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cdu_pkg::word_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cdu_pkg::word_type out_data
);
   import cdu_pkg::*;

   word_type mem_ff [QUEUE_DEPTH];
   logic     wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] n_ff, n_in;
   logic push, pop;

   assign in_ready  = n_ff != 2'(QUEUE_DEPTH);
   assign out_valid = n_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      n_in  = n_ff + {1'b0, push} - {1'b0, pop};
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         n_ff  <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         n_ff  <= n_in;
      end
   end
endmodule

// File: hw/rtl/cdu_back.sv
// Back end: walks header and lists, builds results
module cdu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              word_valid,
   output logic              word_ready,
   input  cdu_pkg::word_type word_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cdu_pkg::rsp_type  rsp_data
);
   import cdu_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [1:0]  wie_ff, wie_in;
   logic [31:0] cnt_ff [4];
   logic [31:0] cnt_in [4];
   logic [31:0] left_ff, left_in;
   logic [31:0] idx_ff, idx_in;
   logic [31:0] held0_ff, held0_in, held1_ff, held1_in;
   logic        ov_ff, ov_in;
   rsp_type     out_ff, out_in;
   logic [2:0]  ph;
   logic [1:0]  wie;
   logic [31:0] c [4];
   logic [2:0]  nph;
   logic [31:0] nleft;
   logic [31:0] sum;
   logic        take;

   assign word_ready = !ov_ff || rsp_ready;
   assign take = word_valid && word_ready;
   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

   // Effective state after an optional record restart
   always_comb begin
      ph  = word_data.record_start ? 3'd0 : phase_ff;
      wie = word_data.record_start ? 2'd0 : wie_ff;
      for (int i = 0; i < 4; i++) begin
         c[i] = word_data.record_start ? 32'd0 : cnt_ff[i];
      end
   end

   // Find next non-empty list after ph, using counts
   always_comb begin
      nph   = PHASE_DONE;
      nleft = 32'd0;
      for (int p = 4; p >= 1; p--) begin
         if (3'(p) > ph && c[p - 1] != 32'd0) begin
            nph   = 3'(p);
            nleft = c[p - 1];
         end
      end
   end

   assign sum = (word_data.record_start ? 32'd0 : idx_ff) + held0_ff;

   always_comb begin
      phase_in = phase_ff;
      wie_in   = wie_ff;
      for (int i = 0; i < 4; i++) cnt_in[i] = cnt_ff[i];
      left_in  = left_ff;
      idx_in   = idx_ff;
      held0_in = held0_ff;
      held1_in = held1_ff;
      ov_in    = ov_ff && !rsp_ready;
      out_in   = out_ff;
      if (take) begin
         phase_in = ph;
         wie_in   = wie;
         for (int i = 0; i < 4; i++) cnt_in[i] = c[i];
         if (word_data.record_start) begin
            left_in = 32'd0;
            idx_in  = 32'd0;
         end
         if (ph == 3'd0) begin
            cnt_in[wie] = word_data.value;
            if (wie != 2'd3) begin
               wie_in = wie + 2'd1;
            end else begin
               wie_in = 2'd0;
               // The search still sees a zero virtual count; test the new one on its own
               out_in = '0;
               out_in.entry_kind     = KIND_HEADER;
               out_in.static_count   = c[0];
               out_in.instance_count = c[1];
               out_in.direct_count   = c[2];
               out_in.virtual_count  = word_data.value;
               ov_in = 1'b1;
               if (nph != PHASE_DONE) begin
                  phase_in = nph;
                  left_in  = nleft;
                  idx_in   = 32'd0;
                  out_in.last_of_record = 1'b0;
               end else if (word_data.value != 32'd0) begin
                  phase_in = KIND_VIRTUAL;
                  left_in  = word_data.value;
                  idx_in   = 32'd0;
                  out_in.last_of_record = 1'b0;
               end else begin
                  phase_in = PHASE_DONE;
                  out_in.last_of_record = 1'b1;
               end
            end
         end else if (ph <= KIND_VIRTUAL) begin
            if (wie == 2'd0) begin
               held0_in = word_data.value;
               wie_in   = 2'd1;
            end else if (wie == 2'd1 && ph >= KIND_DIRECT) begin
               held1_in = word_data.value;
               wie_in   = 2'd2;
            end else begin
               wie_in = 2'd0;
               idx_in = sum;
               out_in = '0;
               out_in.entry_kind  = ph;
               out_in.entry_index = sum;
               if (wie == 2'd1) begin
                  out_in.entry_flags = word_data.value;
                  held1_in = word_data.value;
               end else begin
                  out_in.entry_flags       = held1_ff;
                  out_in.entry_code_offset = word_data.value;
               end
               ov_in   = 1'b1;
               left_in = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  phase_in = nph;
                  idx_in   = 32'd0;
                  left_in  = nleft;
                  out_in.last_of_record = nph == PHASE_DONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      held0_ff <= held0_in;
      held1_ff <= held1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 3'd0;
         wie_ff   <= 2'd0;
         for (int i = 0; i < 4; i++) cnt_ff[i] <= 32'd0;
         left_ff  <= 32'd0;
         idx_ff   <= 32'd0;
         ov_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         wie_ff   <= wie_in;
         for (int i = 0; i < 4; i++) cnt_ff[i] <= cnt_in[i];
         left_ff  <= left_in;
         idx_ff   <= idx_in;
         ov_ff    <= ov_in;
      end
   end
endmodule

// File: hw/rtl/class_data_uleb128_stream_decoder.sv
// Top level of the class-data LEB128 decoder
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | data_byte, record_start
//  rsp     | out       | rsp_valid/ready    | kind, index, flags, offset, counts, last
// One byte per cycle sustained while req_ready is high; the front assembles LEB128 values combinationally.
// A two-word queue separates the front from the list walker, which registers results.
// Without stalls a result is registered first in the queue and then in the walker's result register.
// Synchronous reset clears parser, queue and output valid.
// A held result stalls the walker; the queue then fills and drops req_ready.
module class_data_uleb128_stream_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cdu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cdu_pkg::rsp_type rsp_data
);
   import cdu_pkg::*;

   logic     fw_valid, fw_ready, qw_valid, qw_ready;
   word_type fw_data, qw_data;

   cdu_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .word_valid(fw_valid), .word_ready(fw_ready), .word_data(fw_data)
   );

   cdu_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fw_valid), .in_ready(fw_ready), .in_data(fw_data),
      .out_valid(qw_valid), .out_ready(qw_ready), .out_data(qw_data)
   );

   cdu_back u_back (
      .clock(clock), .reset(reset),
      .word_valid(qw_valid), .word_ready(qw_ready), .word_data(qw_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule

// File: hw/rtl/cdu_checker.sv
// Port-level checker for the decoder, bound to the top level
`include "class_data_uleb128_stream_decoder_assert.svh"
module cdu_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cdu_pkg::rsp_type rsp_data
);
   import cdu_pkg::*;

   `CDU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `CDU_ASSERT_IMPL(a_kind_range, clock, reset, rsp_valid, rsp_data.entry_kind <= KIND_VIRTUAL)
   `CDU_ASSERT_IMPL(a_hdr_zero, clock, reset, rsp_valid && rsp_data.entry_kind == KIND_HEADER, rsp_data.entry_index == 32'd0 && rsp_data.entry_flags == 32'd0)
   `CDU_ASSERT_IMPL(a_field_nocode, clock, reset, rsp_valid && rsp_data.entry_kind >= KIND_STATIC && rsp_data.entry_kind < KIND_DIRECT, rsp_data.entry_code_offset == 32'd0 && rsp_data.static_count == 32'd0)
endmodule

bind class_data_uleb128_stream_decoder cdu_checker u_cdu_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
